[hw/rtl/latc_pkg.sv]
// Shared types and constants for the logic analyzer trigger and capture block.
package latc_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 4096;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_SEL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_MASK     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_VALUE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_BEFORE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_AFTER     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POST_SAMPLES   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_LIMIT  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_THRESHOLD = 3'd7;

    localparam logic [1:0] MODE_LEVEL_MATCH    = 2'd0;
    localparam logic [1:0] MODE_LEVEL_MISMATCH = 2'd1;
    localparam logic [1:0] MODE_EDGE_PAIR      = 2'd2;
    localparam logic [1:0] MODE_FREE_RUN       = 2'd3;

    localparam logic [1:0] OP_CAPTURE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ARM     = 2'd2;

    localparam logic [1:0]  RST_TRIG_SEL       = MODE_LEVEL_MATCH;
    localparam logic [3:0]  RST_PROBE_MASK     = 4'hf;
    localparam logic [16:0] RST_POST_SAMPLES   = 17'h1ffff;
    localparam logic [12:0] RST_CAPTURE_LIMIT  = 13'd4096;
    localparam logic [7:0]  RST_SLOW_THRESHOLD = 8'hff;

    typedef struct packed {
        logic [1:0] trig_sel;
        logic [3:0] probe_mask;
        logic [3:0] level_value;
        logic [3:0] edge_before;
        logic [3:0] edge_after;
        logic [7:0] slow_threshold;
    } t_trig_cfg;

    typedef struct packed {
        logic [3:0] masked;
        logic [3:0] prev_masked;
        logic       prev_valid;
        logic [7:0] prev_time;
        logic [7:0] timestamp;
    } t_trig_in;

    typedef struct packed {
        logic hit;
        logic slow;
    } t_trig_res;

endpackage

[hw/rtl/logic_analyzer_trigger_capture.sv]
// Top level of the four-probe logic analyzer trigger and capture engine.
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_ready  i_operation i_probes i_timestamp i_read_index
//  result    out        o_valid / i_ready  o_entry_* o_trigger_* o_capture_done o_sample_count
//  config    in         i_cfg_we           i_cfg_index i_cfg_data
//
// One request is accepted per cycle while the output register is empty or i_ready is high; its result
// appears in the output register in the next cycle. The sample memory port has a registered read.
// The output register holds while i_ready is low and a new request is taken when it drains.
// Reset is synchronous and active low; the sample memory is not cleared, reads are bounded
// by the stored count.
module logic_analyzer_trigger_capture #(
    parameter int BUFFER_DEPTH = latc_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_operation,
    input  logic [3:0]                        i_probes,
    input  logic [7:0]                        i_timestamp,
    input  logic [11:0]                       i_read_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [3:0]                        o_entry_probes,
    output logic                              o_trigger_hit,
    output logic                              o_slow_sample,
    output logic [7:0]                        o_entry_time,
    output logic                              o_triggered,
    output logic [11:0]                       o_trigger_position,
    output logic                              o_capture_done,
    output logic [12:0]                       o_sample_count,
    input  logic                              i_cfg_we,
    input  logic [latc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [latc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int CNT_MAX = (BUFFER_DEPTH < 8191) ? BUFFER_DEPTH : 8191;
    localparam int CW      = $clog2(CNT_MAX + 1);

    latc_pkg::t_trig_cfg r_cfg;
    logic signed [16:0]  r_post_samples;
    logic [12:0]         r_capture_limit;

    logic [CW-1:0]       r_count, n_count;
    logic [3:0]          r_prev_masked, n_prev_masked;
    logic                r_prev_valid, n_prev_valid;
    logic [7:0]          r_prev_time, n_prev_time;
    logic                r_trig, n_trig;
    logic [CW-1:0]       r_trig_idx, n_trig_idx;
    logic signed [16:0]  r_post_rem, n_post_rem;
    logic                r_stopped, n_stopped;

    logic [13:0]         r_store [BUFFER_DEPTH];
    logic [13:0]         r_rdata;

    logic                r_out_valid;
    logic                r_from_mem;
    logic [13:0]         r_entry, n_entry;
    logic                r_o_trig;
    logic [11:0]         r_o_pos;
    logic                r_o_done;
    logic [12:0]         r_o_count;

    logic                w_accept;
    logic                w_we;
    logic                w_re;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic                w_full_now;
    logic                w_full_next;
    logic [CW-1:0]       w_count_inc;
    logic [3:0]          w_masked;

    latc_pkg::t_trig_in  w_smp;
    latc_pkg::t_trig_res w_res;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_masked = i_probes & r_cfg.probe_mask;

    assign w_smp.masked      = w_masked;
    assign w_smp.prev_masked = r_prev_masked;
    assign w_smp.prev_valid  = r_prev_valid;
    assign w_smp.prev_time   = r_prev_time;
    assign w_smp.timestamp   = i_timestamp;

    latc_trig u_trig (
        .i_cfg (r_cfg),
        .i_smp (w_smp),
        .o_res (w_res)
    );

    assign w_count_inc = r_count + 1'b1;
    assign w_full_now  = (13'(r_count) >= r_capture_limit) ||
                         (32'(r_count) >= 32'(BUFFER_DEPTH));
    assign w_full_next = (13'(w_count_inc) >= r_capture_limit) ||
                         (32'(w_count_inc) >= 32'(BUFFER_DEPTH));
    assign w_waddr     = AW'(r_count);
    assign w_raddr     = AW'(i_read_index);

    always_comb begin
        n_count       = r_count;
        n_prev_masked = r_prev_masked;
        n_prev_valid  = r_prev_valid;
        n_prev_time   = r_prev_time;
        n_trig        = r_trig;
        n_trig_idx    = r_trig_idx;
        n_post_rem    = r_post_rem;
        n_stopped     = r_stopped;
        n_entry       = '0;
        w_we          = 1'b0;
        w_re          = 1'b0;
        case (i_operation)
            latc_pkg::OP_CAPTURE: begin
                if (!r_stopped) begin
                    if (w_full_now) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_prev_masked = w_masked;
                        n_prev_time   = i_timestamp;
                        n_prev_valid  = 1'b1;
                        if (w_res.hit && !r_trig) begin
                            n_trig     = 1'b1;
                            n_trig_idx = r_count;
                        end
                        if (n_trig && (r_post_rem > 0)) begin
                            n_post_rem = r_post_rem - 17'sd1;
                        end
                        n_entry   = {i_timestamp, w_res.slow, w_res.hit, i_probes};
                        w_we      = w_accept;
                        n_count   = w_count_inc;
                        n_stopped = w_full_next || (n_trig && (n_post_rem == 0));
                    end
                end
            end
            latc_pkg::OP_READ: begin
                w_re = w_accept && (13'(i_read_index) < 13'(r_count));
            end
            latc_pkg::OP_ARM: begin
                n_count       = '0;
                n_prev_masked = '0;
                n_prev_valid  = 1'b0;
                n_prev_time   = '0;
                n_trig        = 1'b0;
                n_trig_idx    = '0;
                n_post_rem    = r_post_samples;
                n_stopped     = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= n_entry;
        end
        if (w_re) begin
            r_rdata <= r_store[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_sel       <= latc_pkg::RST_TRIG_SEL;
            r_cfg.probe_mask     <= latc_pkg::RST_PROBE_MASK;
            r_cfg.level_value    <= '0;
            r_cfg.edge_before    <= '0;
            r_cfg.edge_after     <= '0;
            r_cfg.slow_threshold <= latc_pkg::RST_SLOW_THRESHOLD;
            r_post_samples       <= latc_pkg::RST_POST_SAMPLES;
            r_capture_limit      <= latc_pkg::RST_CAPTURE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                latc_pkg::CFG_TRIG_SEL:       r_cfg.trig_sel       <= i_cfg_data[1:0];
                latc_pkg::CFG_PROBE_MASK:     r_cfg.probe_mask     <= i_cfg_data[3:0];
                latc_pkg::CFG_LEVEL_VALUE:    r_cfg.level_value    <= i_cfg_data[3:0];
                latc_pkg::CFG_EDGE_BEFORE:    r_cfg.edge_before    <= i_cfg_data[3:0];
                latc_pkg::CFG_EDGE_AFTER:     r_cfg.edge_after     <= i_cfg_data[3:0];
                latc_pkg::CFG_POST_SAMPLES:   r_post_samples       <= $signed(i_cfg_data);
                latc_pkg::CFG_CAPTURE_LIMIT:  r_capture_limit      <= i_cfg_data[12:0];
                latc_pkg::CFG_SLOW_THRESHOLD: r_cfg.slow_threshold <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_prev_masked <= '0;
            r_prev_valid  <= 1'b0;
            r_prev_time   <= '0;
            r_trig        <= 1'b0;
            r_trig_idx    <= '0;
            r_post_rem    <= latc_pkg::RST_POST_SAMPLES;
            r_stopped     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count       <= n_count;
                r_prev_masked <= n_prev_masked;
                r_prev_valid  <= n_prev_valid;
                r_prev_time   <= n_prev_time;
                r_trig        <= n_trig;
                r_trig_idx    <= n_trig_idx;
                r_post_rem    <= n_post_rem;
                r_stopped     <= n_stopped;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_from_mem <= w_re;
            r_entry    <= n_entry;
            r_o_trig   <= n_trig;
            r_o_pos    <= 12'(n_trig_idx);
            r_o_done   <= n_stopped;
            r_o_count  <= 13'(n_count);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_entry_probes     = r_from_mem ? r_rdata[3:0]  : r_entry[3:0];
    assign o_trigger_hit      = r_from_mem ? r_rdata[4]    : r_entry[4];
    assign o_slow_sample      = r_from_mem ? r_rdata[5]    : r_entry[5];
    assign o_entry_time       = r_from_mem ? r_rdata[13:6] : r_entry[13:6];
    assign o_triggered        = r_o_trig;
    assign o_trigger_position = r_o_pos;
    assign o_capture_done     = r_o_done;
    assign o_sample_count     = r_o_count;

endmodule

[hw/rtl/latc_trig.sv]
// Trigger condition and slow-sample evaluation for one captured sample.
module latc_trig (
    input  latc_pkg::t_trig_cfg i_cfg,
    input  latc_pkg::t_trig_in  i_smp,
    output latc_pkg::t_trig_res o_res
);

    logic [7:0] w_delta;

    always_comb begin
        case (i_cfg.trig_sel)
            latc_pkg::MODE_LEVEL_MATCH:    o_res.hit = (i_smp.masked == i_cfg.level_value);
            latc_pkg::MODE_LEVEL_MISMATCH: o_res.hit = (i_smp.masked != i_cfg.level_value);
            latc_pkg::MODE_EDGE_PAIR: begin
                o_res.hit = i_smp.prev_valid && (i_smp.prev_masked == i_cfg.edge_before) &&
                            (i_smp.masked == i_cfg.edge_after);
            end
            default: o_res.hit = 1'b0;
        endcase
        w_delta    = i_smp.prev_valid ? (i_smp.timestamp - i_smp.prev_time) : 8'd0;
        o_res.slow = (w_delta > i_cfg.slow_threshold);
    end

endmodule
